>>> hdl/nps_pkg.sv
// ----------------------------------------------------------------------------
// nps_pkg: shared constants for the nearest point search block
// Field widths, default sizes and command codes.
// ----------------------------------------------------------------------------
`default_nettype none

package nps_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 16;

  localparam int SLOT_W  = 6;   // slot field on the ports
  localparam int LIMIT_W = 36;  // squared distance, unsigned integer (UQ36.0)

  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

endpackage

`default_nettype wire

>>> hdl/nps_req_if.sv
// ----------------------------------------------------------------------------
// nps_req_if: request channel
// Store and query words with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface nps_req_if
  import nps_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();

  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic        [SLOT_W-1:0]     slot;
  logic                         entry_valid;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;
  logic signed [COORD_BITS-1:0] coord_z;
  logic        [LIMIT_W-1:0]    max_dist_sq;

  modport source (
    output valid, cmd, slot, entry_valid, coord_x, coord_y, coord_z, max_dist_sq,
    input  ready
  );

  modport sink (
    input  valid, cmd, slot, entry_valid, coord_x, coord_y, coord_z, max_dist_sq,
    output ready
  );

endinterface

`default_nettype wire

>>> hdl/nps_rsp_if.sv
// ----------------------------------------------------------------------------
// nps_rsp_if: response channel
// Query result words with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface nps_rsp_if
  import nps_pkg::*;
();

  logic               valid;
  logic               ready;
  logic               found;
  logic [SLOT_W-1:0]  nearest_slot;
  logic [LIMIT_W-1:0] best_dist_sq;

  modport source (
    output valid, found, nearest_slot, best_dist_sq,
    input  ready
  );

  modport sink (
    input  valid, found, nearest_slot, best_dist_sq,
    output ready
  );

endinterface

`default_nettype wire

>>> hdl/nps_table.sv
// ----------------------------------------------------------------------------
// nps_table: point table memory
// One write port, one registered read port; each entry holds a valid mark
// and three coordinates. The read tag follows the read data.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_table
  import nps_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int IDX_W = $clog2(MAX_POINTS),
  localparam int ENT_W = 3 * COORD_BITS + 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             we,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [ENT_W-1:0] wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic             rd_vld,
  output logic [IDX_W-1:0] rd_idx,
  output logic [ENT_W-1:0] rd_data
);

  logic [ENT_W-1:0] mem [MAX_POINTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    rd_idx  <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= rd_en;
    end
  end

endmodule

`default_nettype wire

>>> hdl/nps_dist.sv
// ----------------------------------------------------------------------------
// nps_dist: squared distance unit
// Two-stage pipeline shared by every slot of a scan: per-axis difference
// and square, then the sum of the three squares.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_dist
  import nps_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int IDX_W = $clog2(MAX_POINTS),
  localparam int DW    = COORD_BITS + 1,
  localparam int SQ_W  = 2 * DW,
  localparam int SUM_W = SQ_W + 2
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_vld,
  input  logic [IDX_W-1:0]        in_idx,
  input  logic [3*COORD_BITS-1:0] pt,      // {x, y, z}
  input  logic [3*COORD_BITS-1:0] qpt,     // {x, y, z}
  output logic                    busy,
  output logic                    out_vld,
  output logic [IDX_W-1:0]        out_idx,
  output logic [SUM_W-1:0]        out_sum
);

  logic             s1_vld;
  logic [IDX_W-1:0] s1_idx;
  logic [SQ_W-1:0]  sq [3];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic signed [DW-1:0] diff;
    logic        [DW-1:0] mag;

    always_comb begin
      diff = $signed({pt[a*COORD_BITS + COORD_BITS - 1], pt[a*COORD_BITS +: COORD_BITS]})
           - $signed({qpt[a*COORD_BITS + COORD_BITS - 1], qpt[a*COORD_BITS +: COORD_BITS]});
      mag  = diff[DW-1] ? $unsigned(-diff) : $unsigned(diff);
    end

    always_ff @(posedge clk) begin
      sq[a] <= mag * mag;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx  <= in_idx;
    out_idx <= s1_idx;
    out_sum <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      s1_vld  <= in_vld;
      out_vld <= s1_vld;
    end
  end

  assign busy = s1_vld | out_vld;

endmodule

`default_nettype wire

>>> hdl/nearest_point_search_3d.sv
// Store word: written to the table on acceptance; stores may follow back to back.
// Query word: req.ready stays low from acceptance until the result is loaded
//   into the output register. The table read port scans one slot per cycle.
// A finished result waits in the output register; new stores are taken meanwhile.
// Reset: synchronous; a clearing pass over all MAX_POINTS slots marks every slot
//   empty, with req.ready low until it ends.
// ----------------------------------------------------------------------------
// nearest_point_search_3d: linear scan nearest neighbor over a 3D point table
// Sequencer, best-so-far tracking and output register around the table
// memory and the shared squared distance unit.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_point_search_3d
  import nps_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  nps_req_if.sink    req,
  nps_rsp_if.source  rsp
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int ENT_W = 3 * COORD_BITS + 1;
  localparam int SUM_W = 2 * (COORD_BITS + 1) + 2;
  localparam int CMP_W = (SUM_W > LIMIT_W) ? SUM_W : LIMIT_W;
  localparam int AW    = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(MAX_POINTS - 1);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  logic [IDX_W-1:0]        addr;
  logic [3*COORD_BITS-1:0] qpt;
  logic [LIMIT_W-1:0]      q_limit;
  logic [LIMIT_W-1:0]      best;
  logic [IDX_W-1:0]        best_slot;
  logic                    hit;

  logic                    out_valid;
  logic                    out_found;
  logic [SLOT_W-1:0]       out_slot;
  logic [LIMIT_W-1:0]      out_best;

  logic                    accept;
  logic                    store_ok;
  logic [AW-1:0]           slot_ext;
  logic [AW-1:0]           best_ext;

  logic                    we;
  logic [IDX_W-1:0]        wr_addr;
  logic [ENT_W-1:0]        wr_data;

  logic                    rd_vld;
  logic [IDX_W-1:0]        rd_idx;
  logic [ENT_W-1:0]        rd_data;

  logic                    dist_busy;
  logic                    d_vld;
  logic [IDX_W-1:0]        d_idx;
  logic [SUM_W-1:0]        d_sum;
  logic                    closer;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid & req.ready;
  assign slot_ext  = AW'(req.slot);
  assign store_ok  = (32'(req.slot) < 32'(MAX_POINTS));

  // write port: clearing pass or store word
  always_comb begin
    we      = 1'b0;
    wr_addr = addr;
    wr_data = '0;
    if (state == ST_CLEAR) begin
      we = 1'b1;
    end else if (accept && req.cmd == CMD_STORE && store_ok) begin
      we      = 1'b1;
      wr_addr = slot_ext[IDX_W-1:0];
      wr_data = {req.entry_valid, req.coord_x, req.coord_y, req.coord_z};
    end
  end

  nps_table #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (state == ST_SCAN),
    .rd_addr (addr),
    .rd_vld  (rd_vld),
    .rd_idx  (rd_idx),
    .rd_data (rd_data)
  );

  nps_dist #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (rd_vld & rd_data[ENT_W-1]),
    .in_idx  (rd_idx),
    .pt      (rd_data[3*COORD_BITS-1:0]),
    .qpt     (qpt),
    .busy    (dist_busy),
    .out_vld (d_vld),
    .out_idx (d_idx),
    .out_sum (d_sum)
  );

  // strict compare: earlier slot keeps a tie
  assign closer = d_vld && (CMP_W'(d_sum) < CMP_W'(best));

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (addr == LAST) state_next = ST_IDLE;
      ST_IDLE:  if (accept && req.cmd == CMD_QUERY) state_next = ST_SCAN;
      ST_SCAN:  if (addr == LAST) state_next = ST_DRAIN;
      ST_DRAIN: if (!rd_vld && !dist_busy) state_next = ST_DONE;
      ST_DONE:  if (!out_valid || rsp.ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      addr  <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR || state == ST_SCAN) begin
        addr <= (addr == LAST) ? '0 : addr + 1'b1;
      end
    end
  end

  // query registers and running best
  always_ff @(posedge clk) begin
    if (accept && req.cmd == CMD_QUERY) begin
      qpt       <= {req.coord_x, req.coord_y, req.coord_z};
      q_limit   <= req.max_dist_sq;
      best      <= req.max_dist_sq;
      best_slot <= '0;
      hit       <= 1'b0;
    end else if (closer) begin
      best      <= LIMIT_W'(d_sum);
      best_slot <= d_idx;
      hit       <= 1'b1;
    end
  end

  assign best_ext = AW'(best_slot);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && (!out_valid || rsp.ready)) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!out_valid || rsp.ready)) begin
      out_found <= hit;
      out_slot  <= best_ext[SLOT_W-1:0];
      out_best  <= best;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.found        = out_found;
  assign rsp.nearest_slot = out_slot;
  assign rsp.best_dist_sq = out_best;

  // running best never rises above the query limit
  a_best_le_limit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN || state == ST_DRAIN || state == ST_DONE) |-> best <= q_limit)
    else $error("running best above query limit");

  // a hit always lies strictly inside the limit
  a_hit_inside: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SCAN || state == ST_DRAIN || state == ST_DONE) && hit)
      |-> best < q_limit)
    else $error("hit with best not below limit");

  // pipeline is empty whenever new words are taken
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!rd_vld && !dist_busy && !d_vld))
    else $error("distance pipeline busy while idle");

  // a scan always starts at slot zero
  a_scan_start: assert property (@(posedge clk) disable iff (rst)
    $rose(state == ST_SCAN) |-> addr == '0)
    else $error("scan did not start at slot zero");

  // a new result appears only out of the done state
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result loaded outside done state");

endmodule

`default_nettype wire
